### design/smpq_pkg.sv
// Shared types and constants for the sorted minimum priority queue.
// Used by the queue cell and by the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package smpq_pkg;

  localparam int CAPACITY_DEFAULT = 16;
  localparam int KEY_W = 32;
  localparam int STATUS_W = 2;
  localparam int FILL_W = 5;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  localparam logic signed [KEY_W-1:0] EMPTY_KEY = -32'sd1;

  typedef struct packed {
    logic update;
    logic op;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### design/smpq_cell.sv
// One cell of the sorted key chain: holds one key and shifts it toward
// its neighbors on enqueue and dequeue. Depends on smpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smpq_cell (
  input  wire                                 clk,
  input  wire  smpq_pkg::cell_ctrl_t          ctrl,
  input  wire  logic signed [smpq_pkg::KEY_W-1:0] key_in,
  input  wire                                 occupied,
  input  wire                                 left_greater,
  input  wire  logic signed [smpq_pkg::KEY_W-1:0] left_key,
  input  wire  logic signed [smpq_pkg::KEY_W-1:0] right_key,
  output logic                                greater,
  output logic signed [smpq_pkg::KEY_W-1:0]   key
);
  import smpq_pkg::*;

  logic signed [KEY_W-1:0] key_next;

  assign greater = !occupied || (key_in < key);

  always_comb begin
    key_next = key;
    if (ctrl.op == OP_DEQUEUE) begin
      key_next = right_key;
    end else if (greater) begin
      key_next = left_greater ? left_key : key_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.update) begin
      key <= key_next;
    end
  end

endmodule

`default_nettype wire

### design/sorted_min_priority_queue.sv
// Sorted minimum priority queue built from a chain of key cells.
// The result word is registered and appears in the cycle after its word is accepted.
// Throughput: one word per cycle while the result word is not stalled; every cell compares and shifts in parallel.
// Reset clears the fill count and the result valid flag; stored keys are not
// cleared and are only read below the fill count. Depends on smpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sorted_min_priority_queue #(
  parameter int CAPACITY = smpq_pkg::CAPACITY_DEFAULT
) (
  input  wire                                     clk,
  input  wire                                     rst,
  input  wire                                     in_valid,
  output logic                                    in_ready,
  input  wire                                     op,
  input  wire  logic signed [smpq_pkg::KEY_W-1:0] key_in,
  output logic                                    out_valid,
  input  wire                                     out_ready,
  output logic signed [smpq_pkg::KEY_W-1:0]       popped_key,
  output logic [smpq_pkg::STATUS_W-1:0]           status,
  output logic                                    front_valid,
  output logic signed [smpq_pkg::KEY_W-1:0]       front_key,
  output logic [smpq_pkg::FILL_W-1:0]             fill_count
);
  import smpq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] count;
  logic accept;
  logic is_full;
  logic is_empty;
  logic do_update;
  cell_ctrl_t ctrl;

  logic signed [KEY_W-1:0] cell_key [CAPACITY];
  logic [CAPACITY-1:0] cell_greater;
  logic [CAPACITY-1:0] cell_occupied;

  assign in_ready = !out_valid || out_ready;
  assign accept = in_valid && in_ready;
  assign is_full = (count == CNT_W'(CAPACITY));
  assign is_empty = (count == '0);
  assign do_update = accept &&
                     ((op == OP_ENQUEUE) ? !is_full : !is_empty);
  assign ctrl = '{update: do_update, op: op};

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic left_greater;
      logic signed [KEY_W-1:0] left_key;
      logic signed [KEY_W-1:0] right_key;

      assign cell_occupied[i] = (count > CNT_W'(i));

      if (i == 0) begin : g_head
        assign left_greater = 1'b0;
        assign left_key = '0;
      end else begin : g_body
        assign left_greater = cell_greater[i-1];
        assign left_key = cell_key[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
        assign right_key = cell_key[i];
      end else begin : g_inner
        assign right_key = cell_key[i+1];
      end

      smpq_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .key_in      (key_in),
        .occupied    (cell_occupied[i]),
        .left_greater(left_greater),
        .left_key    (left_key),
        .right_key   (right_key),
        .greater     (cell_greater[i]),
        .key         (cell_key[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (do_update) begin
        count <= (op == OP_ENQUEUE) ? count + 1'b1 : count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (op == OP_ENQUEUE) begin
        popped_key <= '0;
        status <= is_full ? ST_FULL : ST_OK;
      end else begin
        popped_key <= is_empty ? EMPTY_KEY : cell_key[0];
        status <= is_empty ? ST_EMPTY : ST_OK;
      end
    end
  end

  assign front_valid = !is_empty;
  assign front_key = is_empty ? '0 : cell_key[0];
  assign fill_count = FILL_W'(count);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("fill count exceeds capacity");

  a_enqueue_grows: assert property (@(posedge clk) disable iff (rst)
    accept && op == OP_ENQUEUE && !is_full |=> count == $past(count) + 1'b1)
    else $error("enqueue did not grow the queue");

  a_dequeue_shrinks: assert property (@(posedge clk) disable iff (rst)
    accept && op == OP_DEQUEUE && !is_empty |=> count == $past(count) - 1'b1)
    else $error("dequeue did not shrink the queue");

  a_empty_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> popped_key == EMPTY_KEY && !front_valid)
    else $error("empty dequeue word is inconsistent");

  a_front_sorted: assert property (@(posedge clk) disable iff (rst)
    accept && op == OP_ENQUEUE && !is_full && key_in < cell_key[0] |=>
    front_key == $past(key_in))
    else $error("smaller key did not reach the front");

endmodule

`default_nettype wire

### verif/tb.sv
// Self-checking testbench for the sorted minimum priority queue.
// A burst driver and a stalling monitor run against a queue-based predictor.
// Depends on smpq_pkg and sorted_min_priority_queue.
`timescale 1ns / 1ps

module tb;
  import smpq_pkg::*;

  typedef struct packed {
    logic op;
    logic [KEY_W-1:0] key;
  } queue_cmd_t;

  typedef struct packed {
    logic [KEY_W-1:0] popped;
    logic [STATUS_W-1:0] st;
    logic fv;
    logic [KEY_W-1:0] front;
    logic [FILL_W-1:0] fill;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic op = OP_ENQUEUE;
  logic signed [KEY_W-1:0] key_in = '0;
  logic out_ready = 1'b0;
  wire in_ready;
  wire out_valid;
  wire signed [KEY_W-1:0] popped_key;
  wire [STATUS_W-1:0] status;
  wire front_valid;
  wire signed [KEY_W-1:0] front_key;
  wire [FILL_W-1:0] fill_count;

  queue_cmd_t pending_words[$];
  queue_result_t predicted_results[$];
  logic signed [KEY_W-1:0] stored_keys[$];

  int words_total = 0;
  int words_accepted = 0;
  int results_seen = 0;
  int mismatch_count = 0;
  int gen_fill = 0;
  int enqueues = 0;
  int dequeues = 0;
  int empty_pops = 0;
  int full_drops = 0;
  int deepest_fill = 0;
  int burst_left = 0;
  int gap_left = 0;
  int rx_tick = 0;
  int rx_mode = 0;

  sorted_min_priority_queue u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .key_in(key_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .popped_key(popped_key),
    .status(status),
    .front_valid(front_valid),
    .front_key(front_key),
    .fill_count(fill_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void add_word(input logic cmd_op, input logic [KEY_W-1:0] cmd_key);
    queue_cmd_t cmd;
    cmd.op = cmd_op;
    cmd.key = cmd_key;
    pending_words.push_back(cmd);
    words_total++;
    if (cmd_op == OP_ENQUEUE) begin
      if (gen_fill < CAPACITY_DEFAULT) gen_fill++;
    end else if (gen_fill > 0) begin
      gen_fill--;
    end
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: k = $urandom_range(0, 16) - 8;
      4: k = 32'h8000_0000 + $urandom_range(0, 2);
      5: k = 32'h7fff_ffff - $urandom_range(0, 2);
      default: k = $urandom();
    endcase
    return k;
  endfunction

  function automatic queue_result_t apply_word(input queue_cmd_t cmd);
    queue_result_t r;
    int pos;
    r = '0;
    r.st = ST_OK;
    if (cmd.op == OP_ENQUEUE) begin
      enqueues++;
      if (stored_keys.size() >= CAPACITY_DEFAULT) begin
        r.st = ST_FULL;
        full_drops++;
      end else begin
        pos = 0;
        while (pos < stored_keys.size() && !($signed(cmd.key) < stored_keys[pos])) pos++;
        stored_keys.insert(pos, $signed(cmd.key));
      end
    end else begin
      dequeues++;
      if (stored_keys.size() == 0) begin
        r.popped = EMPTY_KEY;
        r.st = ST_EMPTY;
        empty_pops++;
      end else begin
        r.popped = stored_keys.pop_front();
      end
    end
    r.fv = (stored_keys.size() != 0);
    r.front = r.fv ? stored_keys[0] : '0;
    r.fill = FILL_W'(stored_keys.size());
    if (stored_keys.size() > deepest_fill) deepest_fill = stored_keys.size();
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [KEY_W-1:0] got,
                                 input logic [KEY_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("mismatch on result %0d, %s: got %h, expected %h", results_seen, field, got, want);
  endtask

  task automatic check_field(input string field, input logic [KEY_W-1:0] got,
                             input logic [KEY_W-1:0] want);
    if (got !== want) report_mismatch(field, got, want);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_results.push_back(apply_word({op, key_in}));
        words_accepted++;
      end
      if (in_valid && !in_ready) begin
        in_valid <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        queue_cmd_t cmd;
        cmd = pending_words.pop_front();
        in_valid <= 1'b1;
        op <= cmd.op;
        key_in <= cmd.key;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 12);
          gap_left = $urandom_range(0, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      rx_tick++;
      if (rx_tick % 64 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= (rx_tick % 3) != 0;
        2: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= (rx_tick % 16) >= 11;
      endcase
      if (out_valid && out_ready) begin
        queue_result_t want;
        results_seen++;
        if (predicted_results.size() == 0) begin
          report_mismatch("unexpected word", popped_key, '0);
        end else begin
          want = predicted_results.pop_front();
          check_field("popped_key", popped_key, want.popped);
          check_field("status", KEY_W'(status), KEY_W'(want.st));
          check_field("front_valid", KEY_W'(front_valid), KEY_W'(want.fv));
          check_field("front_key", front_key, want.front);
          check_field("fill_count", KEY_W'(fill_count), KEY_W'(want.fill));
        end
      end
    end
  end

  initial begin
    int phase_len;
    int enq_pct;
    add_word(OP_DEQUEUE, 32'h1234_5678);
    add_word(OP_ENQUEUE, 32'h8000_0000);
    add_word(OP_ENQUEUE, 32'h7fff_ffff);
    add_word(OP_ENQUEUE, 32'hffff_ffff);
    add_word(OP_ENQUEUE, 32'h0000_0000);
    add_word(OP_ENQUEUE, 32'h0000_0000);
    add_word(OP_DEQUEUE, 32'hffff_ffff);
    add_word(OP_ENQUEUE, 32'h5555_5555);
    add_word(OP_ENQUEUE, 32'haaaa_aaaa);
    while (gen_fill < CAPACITY_DEFAULT) add_word(OP_ENQUEUE, pick_key());
    add_word(OP_ENQUEUE, 32'h7fff_ffff);
    add_word(OP_DEQUEUE, 32'h0000_0000);
    add_word(OP_DEQUEUE, 32'hffff_ffff);
    while (words_total < 1422) begin
      phase_len = $urandom_range(20, 90);
      case ($urandom_range(0, 4))
        0: enq_pct = 10;
        1: enq_pct = 30;
        2: enq_pct = 50;
        3: enq_pct = 70;
        default: enq_pct = 90;
      endcase
      repeat (phase_len) begin
        if ($urandom_range(0, 99) < enq_pct) add_word(OP_ENQUEUE, pick_key());
        else add_word(OP_DEQUEUE, $urandom());
      end
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    while (words_accepted != words_total || predicted_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Covered %0d words: %0d enqueues, %0d dequeues, deepest fill %0d.",
             words_accepted, enqueues, dequeues, deepest_fill);
    $display("Dequeues on empty: %0d, enqueues dropped on full: %0d, mismatches: %0d.",
             empty_pops, full_drops, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Timed out with %0d of %0d words accepted.", words_accepted, words_total);
    $display("FAIL");
    $finish;
  end

endmodule
